FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the binding point allocator rtl
// no dependencies; taken in by files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high, with a message
`define BPA_ASSERT_MSG(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check with a fixed message
`define BPA_ASSERT(lbl, clk, rst, prop) \
   `BPA_ASSERT_MSG(lbl, clk, rst, prop, "bpa check failed")

`endif

FILE: hw/rtl/bpa_pkg.sv
// binding point allocator package: sizes, codes, command and status types
// no dependencies; used by bpa_ctrl, bpa_dp, binding_point_allocator_unit and the testbench
`default_nettype none

package bpa_pkg;

   localparam int MAX_SLOTS   = 32;
   localparam int NUM_CLASSES = 5;
   localparam int MAP_ENTRIES = 160;
   localparam int NUM_REGS    = 5;
   localparam int LANES       = 16;

   localparam int ROWS      = (MAP_ENTRIES + LANES - 1) / LANES;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int LANE_W    = $clog2(LANES);
   localparam int CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
   localparam int STK_DEPTH = NUM_CLASSES * MAX_SLOTS;
   localparam int STK_AW    = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;

   localparam int SLOT_W    = 5;
   localparam int STATUS_W  = 3;
   localparam int REQ_W     = 2;
   localparam int CLASS_W   = 3;
   localparam int ID_W      = 32;
   localparam int CFG_W     = 6;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [REQ_W-1:0] {
      REQ_ALLOC   = 2'd0,
      REQ_RELEASE = 2'd1,
      REQ_CLEAR   = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ALLOC     = 3'd0,
      ST_BOUND     = 3'd1,
      ST_EXHAUSTED = 3'd2,
      ST_RELEASED  = 3'd3,
      ST_NOTALLOC  = 3'd4,
      ST_CLEARED   = 3'd5
   } status_type;

   localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{6'd8, 6'd32, 6'd16, 6'd16, 6'd1};

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [SLOT_W-1:0] slot;
   } map_entry_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic decide;
      logic pop;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic go_scan;
      logic go_clear;
      logic last_row;
      logic need_pop;
   } stat_type;

   function automatic logic [CNT_W-1:0] class_limit(input logic [CFG_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (int'(v) > MAX_SLOTS) begin
         r = CNT_W'(MAX_SLOTS);
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/binding_point_allocator_unit.sv
// channel   ports                                  beat taken when
// req       start busy req_type req_buffer_class   start && !busy
//           req_buffer_id
// rsp       rsp_valid rsp_slot rsp_status          rsp_valid (one cycle, no stall)
// csr       csr_valid csr_ready csr_index csr_data csr_valid && csr_ready
//
// allocate and release read the id table one 16-entry row per cycle, then pass through
// the S_LAST, S_DECIDE and, when a slot is popped, S_POP states before the registered result strobe
// clear and unknown requests skip the scan and go through S_CLEAR or S_DECIDE before the result
// reset refills every class pool from the register reset values; no clearing pass
// busy stays high until the result strobe; register writes take effect at the next clear
// depends on bpa_pkg, bpa_ctrl, bpa_dp and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module binding_point_allocator_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [bpa_pkg::REQ_W-1:0]         req_type,
   input  logic [bpa_pkg::CLASS_W-1:0]       req_buffer_class,
   input  logic [bpa_pkg::ID_W-1:0]          req_buffer_id,
   output logic                              rsp_valid,
   output logic [bpa_pkg::SLOT_W-1:0]        rsp_slot,
   output logic [bpa_pkg::STATUS_W-1:0]      rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bpa_pkg::CFG_W-1:0]         csr_data
);
   import bpa_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   bpa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   bpa_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_type         (req_type),
      .req_buffer_class (req_buffer_class),
      .req_buffer_id    (req_buffer_id),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_slot         (rsp_slot),
      .rsp_status       (rsp_status)
   );

   `BPA_ASSERT_MSG(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid, "two result beats in a row")
   `BPA_ASSERT_MSG(a_rsp_while_busy, clock, reset, rsp_valid |-> $past(busy), "result beat without a request in flight")
   `BPA_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy)

endmodule

`default_nettype wire

FILE: hw/rtl/bpa_ctrl.sv
// binding point allocator controller: one-hot sequencer over scan, last, decide, pop and clear
// depends on bpa_pkg
`default_nettype none

module bpa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output bpa_pkg::cmd_type cmd,
   input  bpa_pkg::stat_type stat
);
   import bpa_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SCAN   = 6'b000010,
      S_LAST   = 6'b000100,
      S_DECIDE = 6'b001000,
      S_POP    = 6'b010000,
      S_CLEAR  = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (stat.go_clear) begin
                  state_in = S_CLEAR;
               end else if (stat.go_scan) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_SCAN: begin
            cmd.issue = 1'b1;
            if (stat.last_row) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            if (stat.need_pop) begin
               state_in = S_POP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = S_IDLE;
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

FILE: hw/rtl/bpa_dp.sv
// binding point allocator datapath: id table, free slot stacks, limits, result registers
// depends on bpa_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bpa_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [bpa_pkg::REQ_W-1:0]         req_type,
   input  logic [bpa_pkg::CLASS_W-1:0]       req_buffer_class,
   input  logic [bpa_pkg::ID_W-1:0]          req_buffer_id,
   input  logic                              csr_we,
   input  logic [bpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bpa_pkg::CFG_W-1:0]         csr_data,
   input  bpa_pkg::cmd_type                  cmd,
   output bpa_pkg::stat_type                 stat,
   output logic                              rsp_valid,
   output logic [bpa_pkg::SLOT_W-1:0]        rsp_slot,
   output logic [bpa_pkg::STATUS_W-1:0]      rsp_status
);
   import bpa_pkg::*;

   logic [CFG_W-1:0]   cfg_ff [NUM_REGS];

   logic [REQ_W-1:0]   req_ff;
   logic [CLASS_W-1:0] cls_ff;
   logic [ID_W-1:0]    id_ff;

   logic [ROW_W-1:0]   row_ff;
   logic               chk_ff;
   logic [ROW_W-1:0]   rd_row_ff;
   map_entry_type      rd_data_ff [LANES];
   logic [LANES-1:0]   rd_valid_ff;

   logic               match_found_ff;
   logic [ROW_W-1:0]   match_row_ff;
   logic [LANE_W-1:0]  match_lane_ff;
   logic [SLOT_W-1:0]  match_slot_ff;
   logic               free_found_ff;
   logic [ROW_W-1:0]   free_row_ff;
   logic [LANE_W-1:0]  free_lane_ff;

   logic [LANES-1:0]   valid_ff [ROWS];
   map_entry_type      map_mem_ff [ROWS][LANES];

   logic [CNT_W-1:0]   count_ff [NUM_CLASSES];
   logic [CNT_W-1:0]   lim_ff   [NUM_CLASSES];
   logic [CNT_W-1:0]   low_ff   [NUM_CLASSES];

   logic [SLOT_W-1:0]  stack_mem_ff [STK_DEPTH];
   logic [SLOT_W-1:0]  stack_rd_ff;
   logic [CNT_W-1:0]   pop_pos_ff;
   logic               pop_mem_ff;

   logic               rsp_valid_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   status_type         rsp_status_ff;

   logic [CNT_W-1:0]   lim_cfg [NUM_CLASSES];
   logic [CNT_W-1:0]   lim_rst [NUM_CLASSES];
   logic [LANES-1:0]   hit;
   logic [LANES-1:0]   vacant;
   logic [LANE_W-1:0]  hit_lane;
   logic [LANE_W-1:0]  vacant_lane;
   logic               known;
   logic [CLS_W-1:0]   cls_idx;
   logic [CNT_W-1:0]   cnt_cur;
   logic [CNT_W-1:0]   pos_pop;
   logic [CNT_W-1:0]   stk_pos;
   logic [STK_AW-1:0]  stk_addr;
   logic               stk_we;
   logic               stk_re;
   logic               is_alloc;
   logic               is_rel;
   logic               need_pop;
   logic               push_ok;
   logic               rel_hit;
   logic [CNT_W-1:0]   pop_ref;
   logic [SLOT_W-1:0]  pop_slot;
   logic [SLOT_W-1:0]  dec_slot;
   status_type         dec_status;
   map_entry_type      map_wdata;

   // class limits from the live registers and from their reset values
   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (c < NUM_REGS) begin
            lim_cfg[c] = class_limit(cfg_ff[c % NUM_REGS]);
            lim_rst[c] = class_limit(CFG_RESET[c % NUM_REGS]);
         end else begin
            lim_cfg[c] = '0;
            lim_rst[c] = '0;
         end
      end
   end

   // lane compare on the registered table row
   always_comb begin
      hit         = '0;
      vacant      = '0;
      hit_lane    = '0;
      vacant_lane = '0;
      for (int l = 0; l < LANES; l++) begin
         if (int'(rd_row_ff) * LANES + l < MAP_ENTRIES) begin
            hit[l]    = rd_valid_ff[l] && (rd_data_ff[l].id == id_ff);
            vacant[l] = !rd_valid_ff[l];
         end
      end
      for (int l = LANES - 1; l >= 0; l--) begin
         if (hit[l]) begin
            hit_lane = LANE_W'(l);
         end
         if (vacant[l]) begin
            vacant_lane = LANE_W'(l);
         end
      end
   end

   assign known    = (int'(cls_ff) < NUM_CLASSES);
   assign cls_idx  = cls_ff[CLS_W-1:0];
   assign cnt_cur  = count_ff[cls_idx];
   assign pos_pop  = cnt_cur - CNT_W'(1);
   assign is_alloc = (req_ff == REQ_ALLOC);
   assign is_rel   = (req_ff == REQ_RELEASE);
   assign need_pop = is_alloc && !match_found_ff && free_found_ff && known && (cnt_cur != '0);
   assign push_ok  = known && (int'(cnt_cur) < MAX_SLOTS);
   assign rel_hit  = cmd.decide && is_rel && match_found_ff;
   assign stk_pos  = is_rel ? cnt_cur : pos_pop;
   assign stk_addr = STK_AW'(int'(cls_idx) * MAX_SLOTS + int'(stk_pos));
   assign stk_we   = rel_hit && push_ok;
   assign stk_re   = cmd.decide && need_pop;

   // entries below the low mark still hold their refill value
   assign pop_ref  = lim_ff[cls_idx] - pop_pos_ff - CNT_W'(1);
   assign pop_slot = pop_mem_ff ? stack_rd_ff : SLOT_W'(pop_ref);
   assign map_wdata = '{id: id_ff, slot: pop_slot};

   always_comb begin
      dec_slot   = '0;
      dec_status = ST_NOTALLOC;
      case (req_ff)
         REQ_ALLOC: begin
            if (match_found_ff) begin
               dec_slot   = match_slot_ff;
               dec_status = ST_BOUND;
            end else begin
               dec_status = ST_EXHAUSTED;
            end
         end
         REQ_RELEASE: begin
            if (match_found_ff) begin
               dec_slot   = match_slot_ff;
               dec_status = ST_RELEASED;
            end
         end
         default: begin
            dec_status = ST_NOTALLOC;
         end
      endcase
   end

   assign stat.go_scan  = (req_type == REQ_ALLOC) || (req_type == REQ_RELEASE);
   assign stat.go_clear = (req_type == REQ_CLEAR);
   assign stat.last_row = (row_ff == ROW_W'(ROWS - 1));
   assign stat.need_pop = need_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            cfg_ff[r] <= CFG_RESET[r];
         end
      end else if (csr_we && (int'(csr_index) < NUM_REGS)) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_type;
         cls_ff <= req_buffer_class;
         id_ff  <= req_buffer_id;
      end
   end

   // id table scan, one row a beat
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff         <= '0;
         chk_ff         <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
      end else begin
         chk_ff <= cmd.issue;
         if (cmd.load) begin
            row_ff         <= '0;
            match_found_ff <= 1'b0;
            free_found_ff  <= 1'b0;
         end else begin
            if (cmd.issue) begin
               row_ff <= row_ff + ROW_W'(1);
            end
            if (chk_ff && !match_found_ff && (|hit)) begin
               match_found_ff <= 1'b1;
            end
            if (chk_ff && !free_found_ff && (|vacant)) begin
               free_found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_row_ff   <= row_ff;
         rd_data_ff  <= map_mem_ff[row_ff];
         rd_valid_ff <= valid_ff[row_ff];
      end
      if (chk_ff && !match_found_ff && (|hit)) begin
         match_row_ff  <= rd_row_ff;
         match_lane_ff <= hit_lane;
         match_slot_ff <= rd_data_ff[hit_lane].slot;
      end
      if (chk_ff && !free_found_ff && (|vacant)) begin
         free_row_ff  <= rd_row_ff;
         free_lane_ff <= vacant_lane;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         map_mem_ff[free_row_ff][free_lane_ff] <= map_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int r = 0; r < ROWS; r++) begin
            valid_ff[r] <= '0;
         end
      end else begin
         if (rel_hit) begin
            valid_ff[match_row_ff][match_lane_ff] <= 1'b0;
         end
         if (cmd.pop) begin
            valid_ff[free_row_ff][free_lane_ff] <= 1'b1;
         end
      end
   end

   // per class fill count, refill limit and low mark
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            count_ff[c] <= lim_rst[c];
            lim_ff[c]   <= lim_rst[c];
            low_ff[c]   <= lim_rst[c];
         end
      end else if (cmd.clear) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            count_ff[c] <= lim_cfg[c];
            lim_ff[c]   <= lim_cfg[c];
            low_ff[c]   <= lim_cfg[c];
         end
      end else if (cmd.decide) begin
         if (need_pop) begin
            count_ff[cls_idx] <= pos_pop;
            if (pos_pop < low_ff[cls_idx]) begin
               low_ff[cls_idx] <= pos_pop;
            end
         end else if (rel_hit && push_ok) begin
            count_ff[cls_idx] <= cnt_cur + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem_ff[stk_addr] <= match_slot_ff;
      end
      if (stk_re) begin
         stack_rd_ff <= stack_mem_ff[stk_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_re) begin
         pop_pos_ff <= pos_pop;
         pop_mem_ff <= (pos_pop >= low_ff[cls_idx]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (cmd.clear) begin
            rsp_valid_ff  <= 1'b1;
            rsp_slot_ff   <= '0;
            rsp_status_ff <= ST_CLEARED;
         end else if (cmd.decide && !need_pop) begin
            rsp_valid_ff  <= 1'b1;
            rsp_slot_ff   <= dec_slot;
            rsp_status_ff <= dec_status;
         end else if (cmd.pop) begin
            rsp_valid_ff  <= 1'b1;
            rsp_slot_ff   <= pop_slot;
            rsp_status_ff <= ST_ALLOC;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_status = rsp_status_ff;

   `BPA_ASSERT_MSG(a_pop_after_decide, clock, reset, cmd.pop |-> (free_found_ff && !match_found_ff && $past(cmd.decide)), "pop without a free table entry")
   `BPA_ASSERT_MSG(a_release_hits_valid, clock, reset, rel_hit |-> valid_ff[match_row_ff][match_lane_ff], "release of an entry that is not valid")

endmodule

`default_nettype wire

FILE: tb/binding_point_allocator_unit_test.sv
// self-checking testbench for binding_point_allocator_unit: per-class slot pools and id table
// drives request beats and slot count writes, predicts untyped result beats in its own model
// depends on bpa_pkg and binding_point_allocator_unit
`default_nettype none

module binding_point_allocator_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bpa_pkg::*;

   localparam int CLK_PERIOD     = 2;
   localparam int RESET_CYCLES   = 5;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int RECENT_DEPTH   = 48;

   localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

   localparam logic [CLASS_W-1:0] CLS_STORAGE = 3'd0;
   localparam logic [CLASS_W-1:0] CLS_UNIFORM = 3'd1;
   localparam logic [CLASS_W-1:0] CLS_ARRAY   = 3'd2;
   localparam logic [CLASS_W-1:0] CLS_ELEMENT = 3'd3;
   localparam logic [CLASS_W-1:0] CLS_COUNTER = 3'd4;
   localparam logic [CLASS_W-1:0] CLS_BAD_LO  = 3'd5;
   localparam logic [CLASS_W-1:0] CLS_BAD_MID = 3'd6;
   localparam logic [CLASS_W-1:0] CLS_BAD_HI  = 3'd7;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      status_type        status;
   } binding_type;

   typedef struct packed {
      logic [REQ_W-1:0]   op;
      logic [CLASS_W-1:0] cls;
      logic [ID_W-1:0]    id;
      logic               typed;
      binding_type        res;
   } directed_row_type;

   localparam int NUM_ROWS = 22;

   localparam directed_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{REQ_ALLOC,   CLS_STORAGE, 32'h0000_0000, 1'b1, '{5'd0, ST_ALLOC}},
      '{REQ_ALLOC,   CLS_STORAGE, 32'hFFFF_FFFF, 1'b1, '{5'd1, ST_ALLOC}},
      '{REQ_ALLOC,   CLS_UNIFORM, 32'h0000_0000, 1'b1, '{5'd0, ST_BOUND}},
      '{REQ_ALLOC,   CLS_COUNTER, 32'h0000_0005, 1'b1, '{5'd0, ST_ALLOC}},
      '{REQ_ALLOC,   CLS_COUNTER, 32'h0000_0006, 1'b1, '{5'd0, ST_EXHAUSTED}},
      '{REQ_ALLOC,   CLS_BAD_LO,  32'h0000_0007, 1'b1, '{5'd0, ST_EXHAUSTED}},
      '{REQ_ALLOC,   CLS_BAD_HI,  32'h0000_0008, 1'b1, '{5'd0, ST_EXHAUSTED}},
      '{REQ_RELEASE, CLS_STORAGE, 32'h0000_0009, 1'b1, '{5'd0, ST_NOTALLOC}},
      '{REQ_RELEASE, CLS_STORAGE, 32'hFFFF_FFFF, 1'b1, '{5'd1, ST_RELEASED}},
      '{REQ_ALLOC,   CLS_STORAGE, 32'h1234_5678, 1'b1, '{5'd1, ST_ALLOC}},
      '{REQ_RELEASE, CLS_BAD_MID, 32'h0000_0005, 1'b1, '{5'd0, ST_RELEASED}},
      '{REQ_ALLOC,   CLS_COUNTER, 32'hA5A5_A5A5, 1'b0, '{5'd0, ST_ALLOC}},
      '{REQ_RELEASE, CLS_COUNTER, 32'h1234_5678, 1'b0, '{5'd0, ST_ALLOC}},
      '{REQ_ALLOC,   CLS_COUNTER, 32'hA5A5_A5A5, 1'b0, '{5'd0, ST_ALLOC}},
      '{REQ_UNKNOWN, CLS_ELEMENT, 32'h0000_0000, 1'b1, '{5'd0, ST_NOTALLOC}},
      '{REQ_RELEASE, CLS_UNIFORM, 32'h0000_0000, 1'b1, '{5'd0, ST_RELEASED}},
      '{REQ_CLEAR,   CLS_STORAGE, 32'h0000_0000, 1'b1, '{5'd0, ST_CLEARED}},
      '{REQ_ALLOC,   CLS_ARRAY,   32'h8000_0000, 1'b1, '{5'd0, ST_ALLOC}},
      '{REQ_ALLOC,   CLS_ELEMENT, 32'h7FFF_FFFF, 1'b1, '{5'd0, ST_ALLOC}},
      '{REQ_ALLOC,   CLS_UNIFORM, 32'h5555_5555, 1'b0, '{5'd0, ST_ALLOC}},
      '{REQ_RELEASE, CLS_ARRAY,   32'h8000_0000, 1'b0, '{5'd0, ST_ALLOC}},
      '{REQ_ALLOC,   CLS_ARRAY,   32'h0F0F_F0F0, 1'b0, '{5'd0, ST_ALLOC}}
   };

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [REQ_W-1:0]     req_type;
   logic [CLASS_W-1:0]   req_buffer_class;
   logic [ID_W-1:0]      req_buffer_id;
   logic                 rsp_valid;
   logic [SLOT_W-1:0]    rsp_slot;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   // predictor state
   logic [CFG_W-1:0]  slot_count_reg [NUM_REGS];
   logic [SLOT_W-1:0] pool_slot [NUM_CLASSES][MAX_SLOTS];
   int                pool_depth [NUM_CLASSES];
   logic [ID_W-1:0]   bound_id [MAP_ENTRIES];
   logic [SLOT_W-1:0] bound_slot [MAP_ENTRIES];
   logic              bound_live [MAP_ENTRIES];

   binding_type       pending_bindings [$];
   logic [ID_W-1:0]   recent_ids [$];
   int                mismatches;
   int                idle_cycles;
   int                burst_left;

   binding_point_allocator_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_buffer_class (req_buffer_class),
      .req_buffer_id    (req_buffer_id),
      .rsp_valid        (rsp_valid),
      .rsp_slot         (rsp_slot),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic refill_pools();
      int lim;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         lim = (int'(slot_count_reg[c]) > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count_reg[c]);
         pool_depth[c] = lim;
         for (int p = 0; p < MAX_SLOTS; p++) begin
            pool_slot[c][p] = (p < lim) ? SLOT_W'(lim - 1 - p) : '0;
         end
      end
      for (int i = 0; i < MAP_ENTRIES; i++) begin
         bound_live[i] = 1'b0;
      end
   endtask

   task automatic resolve_binding(input logic [REQ_W-1:0] op, input logic [CLASS_W-1:0] cls,
                                  input logic [ID_W-1:0] id, output binding_type res);
      int  hit;
      int  hole;
      int  c;
      bit  known;
      hit        = -1;
      hole       = -1;
      c          = int'(cls);
      known      = c < NUM_CLASSES;
      res.slot   = '0;
      res.status = ST_NOTALLOC;
      for (int i = 0; i < MAP_ENTRIES; i++) begin
         if (bound_live[i] && bound_id[i] == id && hit < 0) hit = i;
         if (!bound_live[i] && hole < 0) hole = i;
      end
      case (op)
         REQ_ALLOC: begin
            if (hit >= 0) begin
               res.slot   = bound_slot[hit];
               res.status = ST_BOUND;
            end else if (!known || hole < 0) begin
               res.status = ST_EXHAUSTED;
            end else if (pool_depth[c] == 0) begin
               res.status = ST_EXHAUSTED;
            end else begin
               pool_depth[c]--;
               res.slot         = pool_slot[c][pool_depth[c]];
               bound_live[hole] = 1'b1;
               bound_id[hole]   = id;
               bound_slot[hole] = res.slot;
               res.status       = ST_ALLOC;
            end
         end
         REQ_RELEASE: begin
            if (hit >= 0) begin
               res.slot        = bound_slot[hit];
               bound_live[hit] = 1'b0;
               if (known && pool_depth[c] < MAX_SLOTS) begin
                  pool_slot[c][pool_depth[c]] = res.slot;
                  pool_depth[c]++;
               end
               res.status = ST_RELEASED;
            end
         end
         REQ_CLEAR: begin
            refill_pools();
            res.status = ST_CLEARED;
         end
         default: ;
      endcase
   endtask

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic hold_off(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_bindings.size() != 0) @(posedge clock);
   endtask

   task automatic pace();
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
         hold_off(($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4));
      end
   endtask

   task automatic issue_request(input logic [REQ_W-1:0] op, input logic [CLASS_W-1:0] cls,
                                input logic [ID_W-1:0] id, input bit typed,
                                input binding_type typed_res);
      binding_type res;
      start            <= 1'b1;
      req_type         <= op;
      req_buffer_class <= cls;
      req_buffer_id    <= id;
      do @(posedge clock); while (busy);
      resolve_binding(op, cls, id, res);
      pending_bindings.insert(pending_bindings.size(), typed ? typed_res : res);
   endtask

   task automatic write_slot_counts(input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] u,
                                    input logic [CFG_W-1:0] v, input logic [CFG_W-1:0] x,
                                    input logic [CFG_W-1:0] a);
      logic [CFG_W-1:0] vals [NUM_REGS];
      vals = '{s, u, v, x, a};
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         slot_count_reg[i] = vals[i];
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CLASS_W-1:0] pick_class();
      if ($urandom_range(0, 15) == 0) return CLASS_W'($urandom_range(CLS_BAD_LO, CLS_BAD_HI));
      return CLASS_W'($urandom_range(CLS_STORAGE, CLS_COUNTER));
   endfunction

   task automatic remember_id(input logic [ID_W-1:0] id);
      recent_ids.insert(recent_ids.size(), id);
      if (recent_ids.size() > RECENT_DEPTH) void'(recent_ids.pop_front());
   endtask

   task automatic mixed_traffic(input int n);
      int               roll;
      logic [ID_W-1:0]  id;
      bit               reuse;
      for (int k = 0; k < n; k++) begin
         roll  = $urandom_range(0, 99);
         reuse = recent_ids.size() != 0 && $urandom_range(0, 9) < ((roll < 55) ? 4 : 8);
         id    = reuse ? recent_ids[$urandom_range(0, recent_ids.size() - 1)] : $urandom;
         if (roll < 55) begin
            issue_request(REQ_ALLOC, pick_class(), id, 1'b0, '0);
            remember_id(id);
         end else if (roll < 90) begin
            issue_request(REQ_RELEASE, pick_class(), id, 1'b0, '0);
         end else if (roll < 95) begin
            issue_request(REQ_CLEAR, CLASS_W'($urandom_range(0, 7)), id, 1'b0, '0);
         end else begin
            issue_request(REQ_UNKNOWN, CLASS_W'($urandom_range(0, 7)), id, 1'b0, '0);
         end
         if ($urandom_range(0, 39) == 0) begin
            drain();
         end else begin
            pace();
         end
      end
   endtask

   task automatic start_phase(input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] u,
                              input logic [CFG_W-1:0] v, input logic [CFG_W-1:0] x,
                              input logic [CFG_W-1:0] a);
      drain();
      write_slot_counts(s, u, v, x, a);
      issue_request(REQ_CLEAR, CLS_STORAGE, $urandom, 1'b0, '0);
      recent_ids.delete();
   endtask

   // response checker
   always @(posedge clock) begin
      binding_type want;
      if (!reset && rsp_valid) begin
         if (pending_bindings.size() == 0) begin
            note_mismatch($sformatf("beat with nothing pending: slot %0d status %0d",
                                    rsp_slot, rsp_status));
         end else begin
            want = pending_bindings.pop_front();
            if (rsp_slot !== want.slot)
               note_mismatch($sformatf("slot: expected %0d, actual %0d", want.slot, rsp_slot));
            if (rsp_status !== want.status)
               note_mismatch($sformatf("status: expected %0d, actual %0d",
                                       want.status, rsp_status));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("binding_point_allocator_unit test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_type         = '0;
      req_buffer_class = '0;
      req_buffer_id    = '0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      mismatches       = 0;
      idle_cycles      = 0;
      burst_left       = 1;
      for (int i = 0; i < NUM_REGS; i++) begin
         slot_count_reg[i] = CFG_RESET[i];
      end
      refill_pools();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < NUM_ROWS; r++) begin
         issue_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].cls, DIRECTED_ROWS[r].id,
                       DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);
         pace();
      end

      // every pool empty
      start_phase(6'd0, 6'd0, 6'd0, 6'd0, 6'd0);
      mixed_traffic(20);

      // all pools at the maximum, then fill the id table past its end
      start_phase(6'd32, 6'd32, 6'd32, 6'd32, 6'd32);
      for (int i = 0; i < MAP_ENTRIES + 5; i++) begin
         logic [ID_W-1:0] id;
         id = $urandom;
         issue_request(REQ_ALLOC, CLASS_W'(i % NUM_CLASSES), id, 1'b0, '0);
         remember_id(id);
         pace();
      end
      mixed_traffic(40);

      // counts above the pool size saturate
      start_phase(6'd63, 6'd63, 6'd33, 6'd63, 6'd0);
      mixed_traffic(60);

      for (int p = 0; p < 3; p++) begin
         start_phase(CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 40)),
                     CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(0, 63)),
                     CFG_W'($urandom_range(1, 4)));
         mixed_traffic(35);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("binding_point_allocator_unit test passed");
      end else begin
         $display("binding_point_allocator_unit test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: binding_point_allocator_unit.f
+incdir+hw/rtl
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_ctrl.sv
hw/rtl/bpa_dp.sv
hw/rtl/binding_point_allocator_unit.sv
tb/binding_point_allocator_unit_test.sv
